// ===== hw/rtl/qoi_pkg.sv =====
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared constants and the product term table of the orientation integrator.
// ----------------------------------------------------------------------------
package qoi_pkg;

    localparam int CompWidth = 32;   // default component width, Q2.(W-2)
    localparam int HalfShift = 11;   // rate Q16.16 * dt Q0.24 -> rate*dt/2 in Q.30
    localparam int MulSplit  = 22;   // low part width of an h term
    localparam int ProdShift = 30;   // product scaling back to Q.30
    localparam int HWidth    = 44;   // magnitude of an h term
    localparam int PWidth    = 48;   // accumulator for a sum component

    typedef struct packed {
        logic [1:0] pi;    // sum component that takes the term
        logic [1:0] hi;    // h term
        logic [1:0] qi;    // orientation component
        logic       sub;   // subtract the term
    } t_term;

    localparam logic [3:0] LastTerm = 4'd11;

    // Hamilton product (0, h) * q, one term per index
    function automatic t_term term_of(input logic [3:0] k);
        t_term t;
        case (k)
            4'd0:    t = '{pi: 2'd0, hi: 2'd0, qi: 2'd1, sub: 1'b1};
            4'd1:    t = '{pi: 2'd0, hi: 2'd1, qi: 2'd2, sub: 1'b1};
            4'd2:    t = '{pi: 2'd0, hi: 2'd2, qi: 2'd3, sub: 1'b1};
            4'd3:    t = '{pi: 2'd1, hi: 2'd0, qi: 2'd0, sub: 1'b0};
            4'd4:    t = '{pi: 2'd1, hi: 2'd1, qi: 2'd3, sub: 1'b0};
            4'd5:    t = '{pi: 2'd1, hi: 2'd2, qi: 2'd2, sub: 1'b1};
            4'd6:    t = '{pi: 2'd2, hi: 2'd1, qi: 2'd0, sub: 1'b0};
            4'd7:    t = '{pi: 2'd2, hi: 2'd2, qi: 2'd1, sub: 1'b0};
            4'd8:    t = '{pi: 2'd2, hi: 2'd0, qi: 2'd3, sub: 1'b1};
            4'd9:    t = '{pi: 2'd3, hi: 2'd2, qi: 2'd0, sub: 1'b0};
            4'd10:   t = '{pi: 2'd3, hi: 2'd0, qi: 2'd2, sub: 1'b0};
            4'd11:   t = '{pi: 2'd3, hi: 2'd1, qi: 2'd1, sub: 1'b1};
            default: t = '{pi: 2'd0, hi: 2'd0, qi: 2'd0, sub: 1'b0};
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/qoi_mul.sv =====
// ----------------------------------------------------------------------------
// qoi_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module qoi_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/qoi_isqrt.sv =====
// ----------------------------------------------------------------------------
// qoi_isqrt
// Integer square root (floor) of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module qoi_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_n;
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_rem >= w_trial) begin
                    r_rem <= r_rem - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

// ===== hw/rtl/qoi_fdiv.sv =====
// ----------------------------------------------------------------------------
// qoi_fdiv
// Restoring fraction divider: m * 2^(F+1) / s, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qoi_fdiv #(
    parameter int F = qoi_pkg::CompWidth - 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [29:0]   i_num,
    input  logic [31:0]   i_den,
    output logic          o_done,
    output logic [F+1:0]  o_quot
);

    localparam int Steps = F + 2;
    localparam int CntW  = $clog2(Steps);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [33:0]     r_rem;
    logic [F+1:0]    r_q;
    logic [33:0]     w_t;

    // first step compares without a shift
    assign w_t = (r_cnt == '0) ? r_rem : (r_rem << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= 34'(i_num);
                r_q    <= '0;
            end else if (r_busy) begin
                if (w_t >= 34'(i_den)) begin
                    r_rem <= w_t - 34'(i_den);
                    r_q   <= {r_q[F:0], 1'b1};
                end else begin
                    r_rem <= w_t;
                    r_q   <= {r_q[F:0], 1'b0};
                end
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntW'(Steps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/quaternion_orientation_integrator_top.sv =====
// Each beat passes through the half-angle terms, the product terms (each multiplied
// in a high and a low part of the h term), the normalizing shifts, the squares, a
// 32-step square root and four bit-serial divisions of CW quotient bits each.
// Throughput: one beat at a time; the input is ready again once the result is taken.
// Reset: synchronous, active low; orientation returns to identity (w = 1).
// ----------------------------------------------------------------------------
// quaternion_orientation_integrator_top
// Integrates angular rate into a stored unit quaternion and renormalizes it.
// ----------------------------------------------------------------------------
module quaternion_orientation_integrator_top #(
    parameter int CW = qoi_pkg::CompWidth
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_rate_x,
    input  logic signed [31:0]   i_rate_y,
    input  logic signed [31:0]   i_rate_z,
    input  logic [23:0]          i_step_time,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_new_w,
    output logic signed [CW-1:0] o_new_x,
    output logic signed [CW-1:0] o_new_y,
    output logic signed [CW-1:0] o_new_z,
    output logic                 o_norm_was_zero
);

    localparam int F  = CW - 2;
    localparam int PW = qoi_pkg::PWidth;
    localparam int HW = qoi_pkg::HWidth;
    localparam logic signed [CW-1:0] One = {2'b01, {F{1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HALF = 4'd1;
    localparam logic [3:0] S_TERM = 4'd2;
    localparam logic [3:0] S_MAG  = 4'd3;
    localparam logic [3:0] S_NORM = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]           r_state;
    logic [3:0]           r_idx;
    logic [1:0]           r_ph;
    logic                 r_go;
    logic                 r_flag;
    logic signed [CW-1:0] r_ori [4];
    logic [31:0]          r_rmag [3];
    logic                 r_rneg [3];
    logic [23:0]          r_dt;
    logic [HW-1:0]        r_hmag [3];
    logic [31:0]          r_qmag [4];
    logic                 r_qneg [4];
    logic signed [PW-1:0] r_p [4];
    logic [PW-1:0]        r_m [4];
    logic                 r_neg [4];
    logic [75:0]          r_acc;
    logic [63:0]          r_n;
    logic [31:0]          r_s;

    logic [CW-1:0]        w_omag [4];
    logic [31:0]          w_q30 [4];
    logic [31:0]          w_in_rate [3];
    logic [31:0]          w_mul_a;
    logic [31:0]          w_mul_b;
    logic [63:0]          w_prod;
    qoi_pkg::t_term       w_t;
    logic [75:0]          w_sum;
    logic signed [PW-1:0] w_res;
    logic                 w_tneg;
    logic                 w_any_hi;
    logic                 w_all_lo;
    logic                 w_all_zero;
    logic                 w_sq_done;
    logic [31:0]          w_root;
    logic                 w_dv_done;
    logic [F+1:0]         w_quot;
    logic [F+1:0]         w_q1;
    logic [F+1:0]         w_v;
    logic [CW-1:0]        w_vs;

    assign w_in_rate[0] = i_rate_x;
    assign w_in_rate[1] = i_rate_y;
    assign w_in_rate[2] = i_rate_z;

    // stored components brought to Q2.30 magnitudes
    for (genvar gi = 0; gi < 4; gi++) begin : g_q30
        assign w_omag[gi] = r_ori[gi][CW-1] ? CW'(-r_ori[gi]) : r_ori[gi];
        if (F >= 30) begin : g_down
            assign w_q30[gi] = 32'(w_omag[gi] >> (F - 30));
        end else begin : g_up
            assign w_q30[gi] = 32'(w_omag[gi]) << (30 - F);
        end
    end

    assign w_t    = qoi_pkg::term_of(r_idx);
    assign w_sum  = r_acc + 76'(w_prod);
    assign w_res  = PW'(w_sum >> qoi_pkg::ProdShift);
    assign w_tneg = r_rneg[w_t.hi] ^ r_qneg[w_t.qi] ^ w_t.sub;

    always_comb begin
        w_any_hi   = 1'b0;
        w_all_lo   = 1'b1;
        w_all_zero = 1'b1;
        for (int i = 0; i < 4; i++) begin
            w_any_hi   = w_any_hi | (|r_m[i][PW-1:30]);
            w_all_lo   = w_all_lo & ~(|r_m[i][PW-1:29]);
            w_all_zero = w_all_zero & ~(|r_m[i]);
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_HALF: begin
                w_mul_a = r_rmag[r_idx[1:0]];
                w_mul_b = 32'(r_dt);
            end
            S_TERM: begin
                w_mul_b = r_qmag[w_t.qi];
                if (r_ph == 2'd0) begin
                    w_mul_a = 32'(r_hmag[w_t.hi] >> qoi_pkg::MulSplit);
                end else begin
                    w_mul_a = 32'(r_hmag[w_t.hi][qoi_pkg::MulSplit-1:0]);
                end
            end
            S_SQ: begin
                w_mul_a = 32'(r_m[r_idx[1:0]][29:0]);
                w_mul_b = 32'(r_m[r_idx[1:0]][29:0]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    qoi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    qoi_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_SQRT)),
        .i_n     (r_n),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    qoi_fdiv #(.F(F)) u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && (r_state == S_DIV)),
        .i_num   (r_m[r_idx[1:0]][29:0]),
        .i_den   (r_s),
        .o_done  (w_dv_done),
        .o_quot  (w_quot)
    );

    // round to nearest and saturate to one; the sign is restored when the component is stored
    assign w_q1 = w_quot + (F+2)'(1);
    assign w_v  = (w_q1 >> 1) > (F+2)'(One) ? (F+2)'(One) : (w_q1 >> 1);
    assign w_vs = CW'(w_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_ph    <= '0;
            r_go    <= 1'b0;
            r_flag  <= 1'b0;
            r_ori[0] <= One;
            r_ori[1] <= '0;
            r_ori[2] <= '0;
            r_ori[3] <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_rneg[i] <= w_in_rate[i][31];
                            r_rmag[i] <= w_in_rate[i][31] ? -w_in_rate[i] : w_in_rate[i];
                        end
                        for (int i = 0; i < 4; i++) begin
                            r_qmag[i] <= w_q30[i];
                            r_qneg[i] <= r_ori[i][CW-1];
                            r_p[i]    <= r_ori[i][CW-1] ? -PW'(w_q30[i]) : PW'(w_q30[i]);
                        end
                        r_dt    <= i_step_time;
                        r_idx   <= '0;
                        r_ph    <= '0;
                        r_state <= S_HALF;
                    end
                end
                S_HALF: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_hmag[r_idx[1:0]] <= HW'(w_prod >> qoi_pkg::HalfShift);
                        r_ph  <= 2'd0;
                        r_idx <= r_idx + 4'd1;
                        if (r_idx == 4'd2) begin
                            r_idx   <= '0;
                            r_state <= S_TERM;
                        end
                    end
                end
                S_TERM: begin
                    case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: begin
                            r_acc <= 76'(w_prod) << qoi_pkg::MulSplit;
                            r_ph  <= 2'd2;
                        end
                        default: begin
                            r_p[w_t.pi] <= w_tneg ? r_p[w_t.pi] - w_res
                                                  : r_p[w_t.pi] + w_res;
                            r_ph  <= 2'd0;
                            r_idx <= r_idx + 4'd1;
                            if (r_idx == qoi_pkg::LastTerm) begin
                                r_state <= S_MAG;
                            end
                        end
                    endcase
                end
                S_MAG: begin
                    for (int i = 0; i < 4; i++) begin
                        r_neg[i] <= r_p[i][PW-1];
                        r_m[i]   <= r_p[i][PW-1] ? PW'(-r_p[i]) : PW'(r_p[i]);
                    end
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (w_all_zero) begin
                        r_ori[0] <= One;
                        r_ori[1] <= '0;
                        r_ori[2] <= '0;
                        r_ori[3] <= '0;
                        r_flag   <= 1'b1;
                        r_state  <= S_OUT;
                    end else if (w_any_hi) begin
                        for (int i = 0; i < 4; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (w_all_lo) begin
                        for (int i = 0; i < 4; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_n     <= '0;
                        r_idx   <= '0;
                        r_ph    <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_n   <= r_n + w_prod;
                        r_ph  <= 2'd0;
                        r_idx <= r_idx + 4'd1;
                        if (r_idx == 4'd3) begin
                            r_go    <= 1'b1;
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    r_go <= 1'b0;
                    if (w_sq_done) begin
                        r_s     <= w_root;
                        r_idx   <= '0;
                        r_go    <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_go <= 1'b0;
                    if (w_dv_done) begin
                        r_ori[r_idx[1:0]] <= r_neg[r_idx[1:0]] ? -w_vs : w_vs;
                        r_idx <= r_idx + 4'd1;
                        r_go  <= 1'b1;
                        if (r_idx == 4'd3) begin
                            r_go    <= 1'b0;
                            r_flag  <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_new_w         = r_ori[0];
    assign o_new_x         = r_ori[1];
    assign o_new_y         = r_ori[2];
    assign o_new_z         = r_ori[3];
    assign o_norm_was_zero = r_flag;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken again right after a beat");

    a_zero_is_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_norm_was_zero) |-> (o_new_w == One && o_new_x == '0 &&
                                          o_new_y == '0 && o_new_z == '0))
        else $error("zero flag without identity");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_new_w <= One && o_new_w >= -One &&
                     o_new_x <= One && o_new_x >= -One))
        else $error("component beyond one");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while a result waits");

endmodule

// ===== sim/quaternion_orientation_integrator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_orientation_integrator_checker
// Watches both channels of the orientation integrator, predicts each updated
// quaternion from the accepted rate beats and compares it with the output.
// ----------------------------------------------------------------------------
module quaternion_orientation_integrator_checker #(
    parameter int CW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_ready_in,
    input  logic signed [31:0]   i_rate_x,
    input  logic signed [31:0]   i_rate_y,
    input  logic signed [31:0]   i_rate_z,
    input  logic [23:0]          i_step_time,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [CW-1:0] i_new_w,
    input  logic signed [CW-1:0] i_new_x,
    input  logic signed [CW-1:0] i_new_y,
    input  logic signed [CW-1:0] i_new_z,
    input  logic                 i_norm_was_zero,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int FB = CW - 2;

    typedef struct {
        logic signed [CW-1:0] w, x, y, z;
        logic                 zero;
    } t_quat;

    longint attitude [4];
    t_quat  expected_quats [$];

    assign o_pending = expected_quats.size();

    function automatic longint unsigned mag_of(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // (a*b) >> 30 on magnitudes, sign applied after truncation
    function automatic longint mul_q30(longint a, longint b);
        logic neg;
        longint unsigned ua, ub, hi, lo, x, y, r;
        neg = (a < 0) != (b < 0);
        ua = mag_of(a);
        ub = mag_of(b) & 64'hFFFF_FFFF;
        hi = (ua >> 22) & 64'h7F_FFFF;
        lo = ua & 64'h3F_FFFF;
        x = hi * ub;
        y = lo * ub;
        r = (x >> 8) + ((((x & 255) << 22) + y) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint to_q30(longint v);
        longint unsigned u;
        u = mag_of(v);
        if (FB >= 30) u = u >> (FB - 30);
        else u = u << (30 - FB);
        return v < 0 ? -longint'(u) : longint'(u);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned round_div(longint unsigned m, longint unsigned s);
        longint unsigned r, qv;
        r = m;
        qv = 0;
        if (r >= s) begin
            r = r - s;
            qv = 1;
        end
        for (int k = 0; k <= FB; k++) begin
            r = r << 1;
            qv = qv << 1;
            if (r >= s) begin
                r = r - s;
                qv = qv | 1;
            end
        end
        return (qv + 1) >> 1;
    endfunction

    function automatic void reset_attitude();
        attitude[0] = longint'(1) << FB;
        attitude[1] = 0;
        attitude[2] = 0;
        attitude[3] = 0;
    endfunction

    function automatic t_quat integrate_rate(logic signed [31:0] rx, logic signed [31:0] ry,
                                             logic signed [31:0] rz, logic [23:0] dt);
        longint h [3];
        longint q [4];
        longint p [4];
        longint unsigned m [4];
        logic neg [4];
        longint unsigned maxm, n, s, v;
        logic signed [31:0] r3 [3];
        t_quat res;
        r3[0] = rx;
        r3[1] = ry;
        r3[2] = rz;
        for (int i = 0; i < 3; i++) begin
            v = (mag_of(longint'(r3[i])) * longint'(dt)) >> 11;
            h[i] = r3[i] < 0 ? -longint'(v) : longint'(v);
        end
        for (int i = 0; i < 4; i++) q[i] = to_q30(attitude[i]);
        p[0] = q[0] - mul_q30(h[0], q[1]) - mul_q30(h[1], q[2]) - mul_q30(h[2], q[3]);
        p[1] = q[1] + mul_q30(h[0], q[0]) + mul_q30(h[1], q[3]) - mul_q30(h[2], q[2]);
        p[2] = q[2] + mul_q30(h[1], q[0]) + mul_q30(h[2], q[1]) - mul_q30(h[0], q[3]);
        p[3] = q[3] + mul_q30(h[2], q[0]) + mul_q30(h[0], q[2]) - mul_q30(h[1], q[1]);
        maxm = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = p[i] < 0;
            m[i] = mag_of(p[i]);
            if (m[i] > maxm) maxm = m[i];
        end
        if (maxm == 0) begin
            reset_attitude();
            res.zero = 1'b1;
        end else begin
            while (maxm >= (64'd1 << 30)) begin
                maxm = maxm >> 1;
                for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
            end
            while (maxm < (64'd1 << 29)) begin
                maxm = maxm << 1;
                for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
            end
            n = 0;
            for (int i = 0; i < 4; i++) n = n + m[i] * m[i];
            s = int_sqrt(n);
            for (int i = 0; i < 4; i++) begin
                v = round_div(m[i], s);
                if (v > (64'd1 << FB)) v = 64'd1 << FB;
                attitude[i] = neg[i] ? -longint'(v) : longint'(v);
            end
            res.zero = 1'b0;
        end
        res.w = attitude[0][CW-1:0];
        res.x = attitude[1][CW-1:0];
        res.y = attitude[2][CW-1:0];
        res.z = attitude[3][CW-1:0];
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        reset_attitude();
    end

    always @(posedge i_clk) begin
        t_quat e;
        if (!i_rst_n) begin
            reset_attitude();
            expected_quats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_quats.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    e = expected_quats.pop_front();
                    if (i_new_w !== e.w) begin
                        $error("new_w: expected %0d, got %0d", e.w, i_new_w);
                        o_fail_count++;
                    end
                    if (i_new_x !== e.x) begin
                        $error("new_x: expected %0d, got %0d", e.x, i_new_x);
                        o_fail_count++;
                    end
                    if (i_new_y !== e.y) begin
                        $error("new_y: expected %0d, got %0d", e.y, i_new_y);
                        o_fail_count++;
                    end
                    if (i_new_z !== e.z) begin
                        $error("new_z: expected %0d, got %0d", e.z, i_new_z);
                        o_fail_count++;
                    end
                    if (i_norm_was_zero !== e.zero) begin
                        $error("norm_was_zero: expected %0d, got %0d", e.zero,
                               i_norm_was_zero);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && i_ready_in)
                expected_quats.push_back(integrate_rate(i_rate_x, i_rate_y, i_rate_z,
                                                        i_step_time));
        end
    end

endmodule

// ===== sim/quaternion_orientation_integrator_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_orientation_integrator_top_test
// Drives rate and time step beats into the integrator under varied idling,
// including extreme rates and steps and repeated steps about single axes.
// ----------------------------------------------------------------------------
module quaternion_orientation_integrator_top_test;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic signed [31:0]  i_rate_x, i_rate_y, i_rate_z;
    logic [23:0]         i_step_time;
    logic                o_valid;
    logic                i_ready;
    logic signed [31:0]  o_new_w, o_new_x, o_new_y, o_new_z;
    logic                o_norm_was_zero;
    int                  fail_count;
    int                  pending;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    quaternion_orientation_integrator_top dut (.*);

    quaternion_orientation_integrator_checker #(.CW(32)) checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready),
        .i_rate_x(i_rate_x), .i_rate_y(i_rate_y), .i_rate_z(i_rate_z),
        .i_step_time(i_step_time),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_new_w(o_new_w), .i_new_x(o_new_x), .i_new_y(o_new_y), .i_new_z(o_new_z),
        .i_norm_was_zero(o_norm_was_zero),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls at the phase rate
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    // hold valid until the beat is taken; the next call or drain drops it
    task automatic send_rate(logic signed [31:0] rx, logic signed [31:0] ry,
                             logic signed [31:0] rz, logic [23:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_rate_x    <= rx;
        i_rate_y    <= ry;
        i_rate_z    <= rz;
        i_step_time <= dt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_rate();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(16'hFFFF)) - 32'sd32768;
            2:       return $signed($urandom_range(32'h3F_FFFF)) - 32'sd2097152;
            default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    function automatic logic [23:0] rand_step();
        case ($urandom_range(2))
            0:       return 24'($urandom);
            1:       return 24'($urandom_range(255));
            default: return $urandom_range(1) ? 24'hFF_FFFF : 24'd0;
        endcase
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_rate_x = '0;
        i_rate_y = '0;
        i_rate_z = '0;
        i_step_time = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, zero step, single axes
        send_rate(0, 0, 0, 24'd0);
        send_rate(32'sh7FFF_FFFF, 0, 0, 24'hFF_FFFF);
        send_rate(32'sh8000_0000, 0, 0, 24'hFF_FFFF);
        send_rate(0, 32'sh7FFF_FFFF, 0, 24'hFF_FFFF);
        send_rate(0, 0, 32'sh8000_0000, 24'hFF_FFFF);
        send_rate(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'hFF_FFFF);
        send_rate(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 24'd1);
        send_rate(-1, -1, -1, 24'hFF_FFFF);
        send_rate(32'sh0001_0000, 0, 0, 24'h00_1000);
        send_rate(0, 0, 0, 24'd5);
        drain();
        repeat (20) @(posedge i_clk);
        // half-unit steps about x, reversed once, then about y and z
        send_rate(32'sh0002_0000, 0, 0, 24'h80_0000);
        send_rate(32'sh0002_0000, 0, 0, 24'h80_0000);
        send_rate(32'shFFFE_0000, 0, 0, 24'h80_0000);
        send_rate(32'sh0002_0000, 0, 0, 24'h80_0000);
        send_rate(32'sh0002_0000, 0, 0, 24'h80_0000);
        send_rate(32'sh0002_0000, 0, 0, 24'h80_0000);
        send_rate(32'sh0002_0000, 0, 0, 24'h80_0000);
        send_rate(32'sh0002_0000, 0, 0, 24'h80_0000);
        send_rate(0, 32'sh0002_0000, 0, 24'h80_0000);
        send_rate(0, 0, 32'sh0002_0000, 24'h80_0000);
        drain();
        repeat (20) @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int n = 0; n < 210; n++) begin
                // mix in repeated half-unit steps about x
                if ($urandom_range(9) == 0)
                    send_rate(32'sh0002_0000, 0, 0, 24'h80_0000);
                else
                    send_rate(rand_rate(), rand_rate(), rand_rate(), rand_step());
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("quaternion_orientation_integrator_top_test: done, clean");
        else
            $display("quaternion_orientation_integrator_top_test: done, errors");
        $finish;
    end

    initial begin
        #40ms;
        $display("quaternion_orientation_integrator_top_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/qoi_pkg.sv
hw/rtl/qoi_mul.sv
hw/rtl/qoi_isqrt.sv
hw/rtl/qoi_fdiv.sv
hw/rtl/quaternion_orientation_integrator_top.sv
sim/quaternion_orientation_integrator_checker.sv
sim/quaternion_orientation_integrator_top_test.sv
